// File: src/plts_pkg.sv
package plts_pkg;

  typedef enum logic [1:0] {
    CFG_TRANSPOSE = 2'd0,
    CFG_SCALE     = 2'd1,
    CFG_ROWS      = 2'd2,
    CFG_COLS      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_TRI = 1'b0,
    FUNC_RHS = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_UPD,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_WB,
    ST_DIVS,
    ST_DIV,
    ST_ORD,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic        func;
    logic [31:0] value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] solution;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic        end_of_run;
    logic        zero_pivot;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a Q32.32 product to Q16.16, ties toward plus infinity, then saturate.
  function automatic logic [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return sat32(64'(d));
  endfunction

endpackage

// File: src/plts_if.sv
interface plts_in_if;
  logic                valid;
  logic                ready;
  plts_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plts_out_if;
  logic                valid;
  logic                ready;
  plts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plts_cfg_if;
  logic                valid;
  logic                ready;
  plts_pkg::cfg_wr_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/plts_div.sv
module plts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plts_pkg::div_req_t req_i,
  output plts_pkg::div_rsp_t rsp_o
);
  import plts_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [32:0] shifted;
  logic [31:0] num_abs;
  logic [47:0] quo_pos;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    num_abs = req_i.num[31] ? 32'(-req_i.num) : req_i.num;
    shifted = {rem_q, dvd_q[47]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = {num_abs, 16'd0};
      den_d  = req_i.den[31] ? 32'(-req_i.den) : req_i.den;
      neg_d  = req_i.num[31] ^ req_i.den[31];
    end else if (busy_q) begin
      // One restoring step per cycle; quotient bits shift in at the bottom.
      if (shifted >= {1'b0, den_q}) begin
        rem_d = 32'(shifted - {1'b0, den_q});
        dvd_d = {dvd_q[46:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        dvd_d = {dvd_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quo_pos = dvd_q;

  always_comb begin
    rsp_o.done = done_q;
    if (!neg_q) begin
      rsp_o.quo = (quo_pos > 48'h0000_7fff_ffff) ? 32'h7fff_ffff : quo_pos[31:0];
    end else begin
      rsp_o.quo = (quo_pos > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-quo_pos[31:0]);
    end
  end

endmodule

// File: src/packed_lower_triangular_solve.sv
// Packed lower triangular solver in signed Q16.16. Send the packed triangle (func 0) and then
// the right-hand matrix by columns (func 1); the right-hand element with last set starts the
// solve, and the block then returns m*n solution elements in column order. Loads are taken one
// per cycle. During a solve no load is taken: each column runs m scaling steps, m*(m-1)/2
// off-diagonal updates and m diagonal divides, the divide being a one-bit-per-cycle restoring
// divider over 48 quotient bits; the results then leave through the solution memory read port,
// each element read in ST_ORD and then offered in ST_OUT, where it waits for ready.
// A zero diagonal yields 0 for that element and flags every result of the solve.
module packed_lower_triangular_solve #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  plts_in_if.sink    in_if,
  plts_cfg_if.sink   cfg_if,
  plts_out_if.source out_if
);
  import plts_pkg::*;

  localparam int TRI_DEPTH   = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int RHS_DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int STORE_DEPTH = TRI_DEPTH + RHS_DEPTH;
  localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XAW = (RHS_DEPTH > 1) ? $clog2(RHS_DEPTH) : 1;
  localparam int IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int JW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int TCW = $clog2(TRI_DEPTH + 1);
  localparam int BCW = $clog2(RHS_DEPTH + 1);

  st_e  st_q, st_d;
  op_e  op_q, op_d;
  logic [JW-1:0]  j_q, j_d;
  logic [IW-1:0]  k_q, k_d, i_q, i_d;
  logic [TCW-1:0] tri_cnt_q, tri_cnt_d;
  logic [BCW-1:0] rhs_cnt_q, rhs_cnt_d;
  logic           zero_q, zero_d;
  logic           tr_q;
  logic [31:0]    alpha_q;
  logic [3:0]     rows_q, cols_q;

  logic [31:0]        acc_q, acc_d, tgt_q, st_rdata_q, x_rdata_q;
  logic signed [63:0] prod_q;

  logic [31:0] store_mem [STORE_DEPTH];
  logic [31:0] x_mem [RHS_DEPTH];

  logic            st_we, st_re, x_we, x_re;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [XAW-1:0]  x_waddr, x_raddr;
  logic [31:0]     st_wdata, x_wdata;
  logic            step_done, col_done, col_start;
  logic [RW-1:0]   m_s;
  logic [CW-1:0]   n_s;
  logic [IW-1:0]   m_last, row_s;
  logic [JW-1:0]   n_last;
  logic [31:0]     mul_a, tgt, r_scale, r_wb;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  function automatic logic [SAW-1:0] tri_addr(input logic [RW-1:0] mm,
                                             input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [15:0] t;
    t = (16'(mm) * 16'd2 - 16'(c) - 16'd1) * 16'(c);
    return SAW'((t >> 1) + 16'(r));
  endfunction

  function automatic logic [XAW-1:0] x_addr(input logic [RW-1:0] mm,
                                           input logic [JW-1:0] c, input logic [IW-1:0] r);
    return XAW'(16'(c) * 16'(mm) + 16'(r));
  endfunction

  always_comb begin
    if (rows_q == 4'd0) begin
      m_s = RW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      m_s = RW'(MAX_ROWS);
    end else begin
      m_s = RW'(rows_q);
    end
    if (cols_q == 4'd0) begin
      n_s = CW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      n_s = CW'(MAX_COLS);
    end else begin
      n_s = CW'(cols_q);
    end
  end

  assign m_last = IW'(m_s - RW'(1));
  assign n_last = JW'(n_s - CW'(1));
  assign row_s  = tr_q ? k_q : i_q;

  assign mul_a   = (op_q == OP_SCALE) ? alpha_q : (tr_q ? x_rdata_q : acc_q);
  assign tgt     = tr_q ? acc_q : x_rdata_q;
  assign r_scale = qround(prod_q);
  assign r_wb    = (op_q == OP_SCALE) ? r_scale : sub_sat(tgt_q, r_scale);

  plts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    st_d      = st_q;
    op_d      = op_q;
    j_d       = j_q;
    k_d       = k_q;
    i_d       = i_q;
    acc_d     = acc_q;
    zero_d    = zero_q;
    tri_cnt_d = tri_cnt_q;
    rhs_cnt_d = rhs_cnt_q;
    st_we     = 1'b0;
    st_waddr  = SAW'(tri_cnt_q);
    st_wdata  = in_if.data.value;
    st_re     = 1'b0;
    st_raddr  = '0;
    x_we      = 1'b0;
    x_waddr   = x_addr(m_s, j_q, i_q);
    x_wdata   = r_wb;
    x_re      = 1'b0;
    x_raddr   = x_addr(m_s, j_q, i_q);
    div_req   = '{start: 1'b0, num: (tr_q ? acc_q : x_rdata_q), den: st_rdata_q};
    step_done = 1'b0;
    col_done  = 1'b0;
    col_start = 1'b0;
    in_if.ready  = 1'b0;
    out_if.valid = 1'b0;

    unique case (st_q)
      ST_LOAD: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.data.func == FUNC_TRI) begin
            if (int'(tri_cnt_q) < TRI_DEPTH) begin
              st_we     = 1'b1;
              tri_cnt_d = tri_cnt_q + TCW'(1);
            end
          end else begin
            if (int'(rhs_cnt_q) < RHS_DEPTH) begin
              st_we     = 1'b1;
              st_waddr  = SAW'(SAW'(TRI_DEPTH) + SAW'(rhs_cnt_q));
              rhs_cnt_d = rhs_cnt_q + BCW'(1);
            end
            if (in_if.data.last) begin
              tri_cnt_d = '0;
              rhs_cnt_d = '0;
              zero_d    = 1'b0;
              j_d       = '0;
              col_start = 1'b1;
              st_d      = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        st_re = 1'b1;
        x_re  = 1'b1;
        unique case (op_q)
          OP_SCALE: st_raddr = SAW'(SAW'(TRI_DEPTH) + SAW'(x_addr(m_s, j_q, row_s)));
          OP_UPD:   st_raddr = tri_addr(m_s, i_q, k_q);
          OP_DIV: begin
            st_raddr = tri_addr(m_s, k_q, k_q);
            x_raddr  = x_addr(m_s, j_q, k_q);
          end
          default:  st_raddr = '0;
        endcase
        st_d = (op_q == OP_DIV) ? ST_DIVS : ST_MUL;
      end
      ST_MUL: st_d = ST_WB;
      ST_WB: begin
        if (tr_q) begin
          acc_d = r_wb;
        end else begin
          x_we = 1'b1;
        end
        step_done = 1'b1;
      end
      ST_DIVS: begin
        if (st_rdata_q == 32'd0) begin
          zero_d    = 1'b1;
          acc_d     = '0;
          x_we      = 1'b1;
          x_waddr   = x_addr(m_s, j_q, k_q);
          x_wdata   = '0;
          step_done = 1'b1;
        end else begin
          div_req.start = 1'b1;
          st_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          acc_d     = div_rsp.quo;
          x_we      = 1'b1;
          x_waddr   = x_addr(m_s, j_q, k_q);
          x_wdata   = div_rsp.quo;
          step_done = 1'b1;
        end
      end
      ST_ORD: begin
        x_re    = 1'b1;
        x_raddr = x_addr(m_s, j_q, i_q);
        st_d    = ST_OUT;
      end
      ST_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) begin
          st_d = ST_ORD;
          if (i_q == m_last) begin
            i_d = '0;
            if (j_q == n_last) begin
              st_d = ST_LOAD;
            end else begin
              j_d = j_q + JW'(1);
            end
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      default: st_d = ST_LOAD;
    endcase

    if (step_done) begin
      st_d = ST_RD;
      if (!tr_q) begin
        unique case (op_q)
          OP_SCALE: begin
            if (i_q == m_last) begin
              op_d = OP_DIV;
              k_d  = '0;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
          OP_DIV: begin
            if (k_q == m_last) begin
              col_done = 1'b1;
            end else begin
              op_d = OP_UPD;
              i_d  = k_q + IW'(1);
            end
          end
          OP_UPD: begin
            if (i_q == m_last) begin
              op_d = OP_DIV;
              k_d  = k_q + IW'(1);
            end else begin
              i_d = i_q + IW'(1);
            end
          end
          default: op_d = OP_SCALE;
        endcase
      end else begin
        // Back substitution: k_q walks the rows upward, i_q the rows below it.
        unique case (op_q)
          OP_SCALE: begin
            if (k_q == m_last) begin
              op_d = OP_DIV;
            end else begin
              op_d = OP_UPD;
              i_d  = k_q + IW'(1);
            end
          end
          OP_UPD: begin
            if (i_q == m_last) begin
              op_d = OP_DIV;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
          OP_DIV: begin
            if (k_q == '0) begin
              col_done = 1'b1;
            end else begin
              k_d  = k_q - IW'(1);
              op_d = OP_SCALE;
            end
          end
          default: op_d = OP_SCALE;
        endcase
      end
    end

    if (col_done) begin
      if (j_q == n_last) begin
        st_d = ST_ORD;
        j_d  = '0;
        i_d  = '0;
      end else begin
        j_d       = j_q + JW'(1);
        col_start = 1'b1;
      end
    end

    if (col_start) begin
      op_d = OP_SCALE;
      i_d  = '0;
      k_d  = tr_q ? m_last : '0;
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_LOAD;
      op_q      <= OP_SCALE;
      j_q       <= '0;
      k_q       <= '0;
      i_q       <= '0;
      tri_cnt_q <= '0;
      rhs_cnt_q <= '0;
      zero_q    <= 1'b0;
      tr_q      <= 1'b0;
      alpha_q   <= 32'h0001_0000;
      rows_q    <= 4'd8;
      cols_q    <= 4'd8;
    end else begin
      st_q      <= st_d;
      op_q      <= op_d;
      j_q       <= j_d;
      k_q       <= k_d;
      i_q       <= i_d;
      tri_cnt_q <= tri_cnt_d;
      rhs_cnt_q <= rhs_cnt_d;
      zero_q    <= zero_d;
      if (cfg_if.valid) begin
        unique case (cfg_if.data.index)
          CFG_TRANSPOSE: tr_q    <= cfg_if.data.data[0];
          CFG_SCALE:     alpha_q <= cfg_if.data.data;
          CFG_ROWS:      rows_q  <= cfg_if.data.data[3:0];
          CFG_COLS:      cols_q  <= cfg_if.data.data[3:0];
          default:       tr_q    <= tr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (st_q == ST_MUL) begin
      prod_q <= $signed(mul_a) * $signed(st_rdata_q);
      tgt_q  <= tgt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= store_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    if (x_re) begin
      x_rdata_q <= x_mem[x_raddr];
    end
  end

  assign out_if.data.solution   = x_rdata_q;
  assign out_if.data.row_index  = 3'(i_q);
  assign out_if.data.col_index  = 3'(j_q);
  assign out_if.data.end_of_run = (i_q == m_last) && (j_q == n_last);
  assign out_if.data.zero_pivot = zero_q;

endmodule

// File: src/plts_checker.sv
module plts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_end_i,
  input logic out_zero_i
);

  // The block never takes a request while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("request accepted while a result is pending");

  // After the final result the block is ready for loads again.
  a_end_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_end_i |=> in_ready_i)
    else $error("block not ready after end of run");

  // A non-final result is followed by a gap in which the next element is read, and then by the next result.
  a_next_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_end_i |=> !out_valid_i ##1 out_valid_i)
    else $error("result stream broken");

  // The pivot flag is the same on every result of one solve.
  a_zero_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_end_i |-> ##2 (out_zero_i == $past(out_zero_i, 2)))
    else $error("zero pivot flag changed within a solve");

  // A result that waits keeps its end-of-run flag.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_end_i))
    else $error("stalled result changed");

endmodule

bind packed_lower_triangular_solve plts_checker u_plts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_end_i   (out_if.data.end_of_run),
  .out_zero_i  (out_if.data.zero_pivot)
);
